FILE: design/bud_pkg.sv
// ----------------------------------------------------------------------------
// bud_pkg
// shared types, status codes and the base64 alphabet map for the decoder
// ----------------------------------------------------------------------------
package bud_pkg;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_TRUNCATED = 2'd1;
   localparam logic [1:0] STATUS_BAD_LEN   = 2'd2;
   localparam logic [1:0] STATUS_BAD_TAIL  = 2'd3;

   localparam int GROUP_BYTES = 3;

   typedef struct packed {
      logic [7:0] char_code;
      logic       end_of_stream;
   } req_word_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       byte_valid;
      logic       stream_done;
      logic [1:0] stream_status;
   } rsp_word_type;

   // results caused by one input word, one to three output words
   typedef struct packed {
      logic [GROUP_BYTES-1:0][7:0] bytes;
      logic [1:0]                  num;
      logic                        byte_valid;
      logic                        done;
      logic [1:0]                  status;
   } group_type;

   typedef struct packed {
      logic       invalid;
      logic [5:0] sextet;
   } sextet_type;

   function automatic sextet_type map_char(input logic [7:0] c);
      sextet_type r;
      r.invalid = 1'b0;
      r.sextet  = 6'd0;
      if (c >= 8'd65 && c <= 8'd90) begin
         r.sextet = 6'(c - 8'd65);
      end else if (c >= 8'd97 && c <= 8'd122) begin
         r.sextet = 6'(c - 8'd71);
      end else if (c >= 8'd48 && c <= 8'd57) begin
         r.sextet = 6'(c + 8'd4);
      end else if (c == 8'd43) begin
         r.sextet = 6'd62;
      end else if (c == 8'd47) begin
         r.sextet = 6'd63;
      end else begin
         r.invalid = 1'b1;
      end
      return r;
   endfunction

endpackage

FILE: design/bud_decode.sv
// ----------------------------------------------------------------------------
// bud_decode
// group state and per-character step: maps a character, gathers sextets and
// forms the bytes and end-of-stream status caused by it
// ----------------------------------------------------------------------------
module bud_decode (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  bud_pkg::req_word_type word,
   output logic                  push,
   output bud_pkg::group_type    group
);

   logic [1:0]  pos_ff, pos_in;
   logic [17:0] acc_ff, acc_in;
   logic        ginv_ff, ginv_in;
   logic        stop_ff, stop_in;

   bud_pkg::sextet_type sx;
   logic        newinv;
   logic [17:0] acc;
   logic        full;
   logic [1:0]  nb;

   always_comb begin
      sx     = bud_pkg::map_char(word.char_code);
      newinv = ginv_ff | sx.invalid;
      acc    = {acc_ff[11:0], sx.sextet};
      full   = (pos_ff == 2'd3);

      group        = '0;
      nb           = 2'd0;
      stop_in      = stop_ff;
      if (full) begin
         pos_in  = 2'd0;
         acc_in  = '0;
         ginv_in = 1'b0;
         if (!stop_ff) begin
            if (newinv) begin
               stop_in = 1'b1;
            end else begin
               group.bytes[0] = acc_ff[17:10];
               group.bytes[1] = acc_ff[9:2];
               group.bytes[2] = {acc_ff[1:0], sx.sextet};
               nb             = 2'd3;
            end
         end
      end else begin
         pos_in  = pos_ff + 2'd1;
         acc_in  = acc;
         ginv_in = newinv;
      end

      if (word.end_of_stream) begin
         if (pos_ff == 2'd0) begin
            group.status = bud_pkg::STATUS_BAD_LEN;
         end else if (stop_in) begin
            group.status = bud_pkg::STATUS_TRUNCATED;
         end else if (!full && newinv) begin
            group.status = bud_pkg::STATUS_BAD_TAIL;
         end else if (pos_ff == 2'd1) begin
            group.bytes[0] = acc[11:4];
            nb             = 2'd1;
         end else if (pos_ff == 2'd2) begin
            group.bytes[0] = acc[17:10];
            group.bytes[1] = acc[9:2];
            nb             = 2'd2;
         end
         pos_in  = 2'd0;
         acc_in  = '0;
         ginv_in = 1'b0;
         stop_in = 1'b0;
      end

      group.byte_valid = (nb != 2'd0);
      group.num        = (nb != 2'd0) ? nb : 2'd1;
      group.done       = word.end_of_stream;
      push             = accept && ((nb != 2'd0) || word.end_of_stream);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         acc_ff  <= '0;
         ginv_ff <= 1'b0;
         stop_ff <= 1'b0;
      end else if (accept) begin
         pos_ff  <= pos_in;
         acc_ff  <= acc_in;
         ginv_ff <= ginv_in;
         stop_ff <= stop_in;
      end
   end

endmodule

FILE: design/bud_resp_queue.sv
// ----------------------------------------------------------------------------
// bud_resp_queue
// two-entry queue of result groups, sent out one word per handshake
// ----------------------------------------------------------------------------
module bud_resp_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  bud_pkg::group_type    group,
   output logic                  full,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output bud_pkg::rsp_word_type rsp_data
);

   bud_pkg::group_type entry_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff, count_in;
   logic [1:0] idx_ff, idx_in;
   logic       last;
   logic       pop;
   bud_pkg::group_type head;

   always_comb begin
      head      = entry_ff[rd_ptr_ff];
      last      = (idx_ff == head.num - 2'd1);
      rsp_valid = (count_ff != 2'd0);
      full      = (count_ff == 2'd2);
      pop       = rsp_valid && !rsp_stall && last;

      rsp_data = '0;
      rsp_data.byte_valid = head.byte_valid;
      if (head.byte_valid) begin
         unique case (idx_ff)
            2'd0:    rsp_data.data_byte = head.bytes[0];
            2'd1:    rsp_data.data_byte = head.bytes[1];
            2'd2:    rsp_data.data_byte = head.bytes[2];
            default: rsp_data.data_byte = 8'd0;
         endcase
      end
      if (head.done && last) begin
         rsp_data.stream_done   = 1'b1;
         rsp_data.stream_status = head.status;
      end

      count_in = count_ff + {1'b0, push} - {1'b0, pop};
      if (pop) begin
         idx_in = 2'd0;
      end else if (rsp_valid && !rsp_stall) begin
         idx_in = idx_ff + 2'd1;
      end else begin
         idx_in = idx_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
         idx_ff    <= '0;
      end else begin
         count_ff <= count_in;
         idx_ff   <= idx_in;
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= group;
      end
   end

endmodule

FILE: design/base64_unpadded_decoder_top.sv
// ----------------------------------------------------------------------------
// base64_unpadded_decoder_top
// the results of each accepted character are registered into the result queue
// throughput: one character per cycle unless the two-group result queue is full,
// which stalls the input; one result word per cycle while rsp_stall is low
// reset: synchronous, clears group state, stop flag and the result queue
// ----------------------------------------------------------------------------
module base64_unpadded_decoder_top (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  bud_pkg::req_word_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output bud_pkg::rsp_word_type rsp_data
);

   logic               accept;
   logic               push;
   logic               full;
   bud_pkg::group_type group;

   assign req_stall = full;
   assign accept    = req_valid && !full;

   bud_decode u_decode (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .word   (req_data),
      .push   (push),
      .group  (group)
   );

   bud_resp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .group     (group),
      .full      (full),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
